// ===== rtl/core/mmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmfc_pkg
// Shared types, command codes and the index-to-color function of the
// min/max false color map.
// ----------------------------------------------------------------------------
package mmfc_pkg;

  // Command codes on command_i
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Quotient bits of (v - min) * 512 / (max - min); a value of 512 is clamped
  localparam int unsigned QUOT_BITS = 10;
  localparam int unsigned IDX_BITS  = 9;
  localparam int unsigned CHAN_BITS = 8;

  typedef logic [QUOT_BITS-1:0] quot_t;
  typedef logic [CHAN_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Clamp the quotient to 511, force 0 on a flat frame, then split into
  // the blue-to-green and green-to-red halves.
  function automatic rgb_t color_of(quot_t quot, logic flat);
    logic [IDX_BITS-1:0] idx;
    rgb_t                rgb;
    if (flat) begin
      idx = '0;
    end else if (quot[QUOT_BITS-1]) begin
      idx = '1;
    end else begin
      idx = quot[IDX_BITS-1:0];
    end
    if (!idx[IDX_BITS-1]) begin
      rgb.red   = '0;
      rgb.green = idx[CHAN_BITS-1:0];
      rgb.blue  = ~idx[CHAN_BITS-1:0];
    end else begin
      rgb.red   = idx[CHAN_BITS-1:0];
      rgb.green = ~idx[CHAN_BITS-1:0];
      rgb.blue  = '0;
    end
    return rgb;
  endfunction

endpackage

// ===== rtl/core/mmfc_ram.sv =====
// ----------------------------------------------------------------------------
// mmfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmfc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mmfc_div.sv =====
// ----------------------------------------------------------------------------
// mmfc_div
// Restoring divider, one quotient bit per cycle: (dividend * 512) / divisor
// for dividend <= divisor, giving a 10-bit quotient.
// ----------------------------------------------------------------------------
module mmfc_div #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [WIDTH-1:0]    divisor_i,
  output logic                done_o,
  output mmfc_pkg::quot_t     quot_o
);

  localparam int unsigned CNT_W = $clog2(mmfc_pkg::QUOT_BITS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             first_q, first_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;
  mmfc_pkg::quot_t  quot_q, quot_d;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  // Shared compare/subtract step
  always_comb begin
    trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // Sequencer
  always_comb begin
    cnt_d   = cnt_q;
    first_d = first_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quot_d  = quot_q;
    if (start_i) begin
      cnt_d   = CNT_W'(mmfc_pkg::QUOT_BITS);
      first_d = 1'b1;
      rem_d   = dividend_i;
      dsr_d   = divisor_i;
      quot_d  = '0;
    end else if (cnt_q != '0) begin
      cnt_d   = cnt_q - CNT_W'(1);
      first_d = 1'b0;
      rem_d   = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quot_d  = {quot_q[mmfc_pkg::QUOT_BITS-2:0], ge};
      done_d  = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    quot_q  <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/minmax_false_color_map.sv =====
// ----------------------------------------------------------------------------
// minmax_false_color_map
// Loads a frame of signed samples while tracking minimum and maximum, then
// returns the pixels in load order as min/max normalized false colors.
// ----------------------------------------------------------------------------
// A load word (command 0) leaves busy_o low, so loads may come every
// cycle while no fetch holds busy_o high; frame_end_i closes the frame. A
// fetch word (command 1) on a closed frame keeps busy_o high while the
// block reads the frame memory and forms offset and range, runs the
// one-bit-per-cycle divider and maps the index to a color. The color
// word then shows for exactly one cycle with done_o high; the receiver
// cannot stall it, so it must take the word in that cycle. A fetch before
// the frame is closed yields no word. The frame memory is not cleared.
// ----------------------------------------------------------------------------
module minmax_false_color_map #(
  parameter int unsigned MAX_PIXELS  = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic signed [15:0] sample_i,
  input  logic        frame_end_i,
  output logic        done_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        last_pixel_o
);

  localparam int unsigned VW     = SAMPLE_BITS;
  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic signed [VW-1:0] low_q, low_d;
  logic signed [VW-1:0] high_q, high_d;
  logic [CNT_W-1:0]    load_count_q, load_count_d;
  logic [CNT_W-1:0]    read_ptr_q, read_ptr_d;
  logic                frame_ready_q, frame_ready_d;
  logic                last_q, last_d;
  logic                flat_q;
  logic                done_q;
  mmfc_pkg::rgb_t      rgb_q;
  logic                last_pixel_q;

  logic signed [VW-1:0] sample_v;
  logic                accept;
  logic                do_load;
  logic                do_fetch;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W-1:0]    rp_eff;
  logic [CNT_W-1:0]    rp_next;
  logic                mem_we;
  logic [VW-1:0]       mem_rdata;
  logic [VW:0]         off_wide;
  logic [VW:0]         range_wide;
  logic                div_start;
  logic                div_done;
  mmfc_pkg::quot_t     div_quot;

  // Take the low SAMPLE_BITS bits as signed; wider settings zero-extend
  if (SAMPLE_BITS <= 16) begin : g_narrow
    assign sample_v = signed'(sample_i[SAMPLE_BITS-1:0]);
  end else begin : g_wide
    assign sample_v = signed'({{(SAMPLE_BITS-16){1'b0}}, sample_i});
  end

  assign accept   = start_i && (state_q == ST_IDLE);
  assign do_load  = accept && (command_i == mmfc_pkg::CMD_LOAD);
  assign do_fetch = accept && (command_i == mmfc_pkg::CMD_FETCH)
                    && frame_ready_q && (load_count_q != '0);

  // A load after a closed frame starts a new one
  assign eff_count = frame_ready_q ? '0 : load_count_q;
  assign mem_we    = do_load && (eff_count < CNT_W'(MAX_PIXELS));

  // Fetch pointer with wrap
  assign rp_eff  = (read_ptr_q >= load_count_q) ? '0 : read_ptr_q;
  assign rp_next = rp_eff + CNT_W'(1);

  // Offset and range from the stored sample and the frame extremes
  assign off_wide   = {mem_rdata[VW-1], mem_rdata} - {low_q[VW-1], low_q};
  assign range_wide = {high_q[VW-1], high_q} - {low_q[VW-1], low_q};
  assign div_start  = (state_q == ST_READ);

  // Control and frame bookkeeping
  always_comb begin
    state_d       = state_q;
    low_d         = low_q;
    high_d        = high_q;
    load_count_d  = load_count_q;
    read_ptr_d    = read_ptr_q;
    frame_ready_d = frame_ready_q;
    last_d        = last_q;
    case (state_q)
      ST_IDLE: begin
        if (do_load) begin
          load_count_d  = eff_count;
          if (mem_we) begin
            if (eff_count == '0) begin
              low_d  = sample_v;
              high_d = sample_v;
            end else begin
              if (sample_v < low_q)  low_d  = sample_v;
              if (sample_v > high_q) high_d = sample_v;
            end
            load_count_d = eff_count + CNT_W'(1);
          end
          frame_ready_d = frame_end_i;
          if (frame_ready_q || frame_end_i) begin
            read_ptr_d = '0;
          end
        end else if (do_fetch) begin
          last_d     = (rp_next == load_count_q);
          read_ptr_d = (rp_next == load_count_q) ? '0 : rp_next;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      low_q         <= '0;
      high_q        <= '0;
      load_count_q  <= '0;
      read_ptr_q    <= '0;
      frame_ready_q <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      low_q         <= low_d;
      high_q        <= high_d;
      load_count_q  <= load_count_d;
      read_ptr_q    <= read_ptr_d;
      frame_ready_q <= frame_ready_d;
      done_q        <= (state_q == ST_DIV) && div_done;
    end
  end

  // Per-fetch payload registers
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (div_start) begin
      flat_q <= (high_q == low_q);
    end
    if ((state_q == ST_DIV) && div_done) begin
      rgb_q        <= mmfc_pkg::color_of(div_quot, flat_q);
      last_pixel_q <= last_q;
    end
  end

  // Frame store
  mmfc_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (eff_count[ADDR_W-1:0]),
    .wdata_i (sample_v),
    .re_i    (do_fetch),
    .raddr_i (rp_eff[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Shared divider
  mmfc_div #(
    .WIDTH (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_wide[VW-1:0]),
    .divisor_i  (range_wide[VW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign red_o        = rgb_q.red;
  assign green_o      = rgb_q.green;
  assign blue_o       = rgb_q.blue;
  assign last_pixel_o = last_pixel_q;

  // A color word only follows the divide phase
  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_DIV)
    else $error("color word without a divide phase");

  // A fetch on a closed, non-empty frame makes the block busy
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fetch |=> busy_o)
    else $error("fetch did not start the sequencer");

  // Read pointer never passes the pixel count
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_ptr_q <= load_count_q)
    else $error("read pointer beyond frame");

  // Pixel count bounded by the frame store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond frame store");

endmodule

// ===== test/minmax_false_color_map_checker.sv =====
// ----------------------------------------------------------------------------
// minmax_false_color_map_checker
// Watches the command and color channels of the false color map. It keeps
// its own copy of the frame, the running min/max and the fetch position,
// predicts the color word of every accepted fetch on a closed frame, and
// compares it field by field with the next done_o word.
// ----------------------------------------------------------------------------
module minmax_false_color_map_checker #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               command_i,
  input  logic signed [15:0] sample_i,
  input  logic               frame_end_i,
  input  logic               done_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               last_pixel_i,
  output int                 mismatch_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } color_word_t;

  // Shadow of the frame and of the normalization state
  logic signed [15:0] frame_mem [MAX_PIXELS];
  logic signed [15:0] min_sample;
  logic signed [15:0] max_sample;
  logic [16:0]        pixel_count;
  logic [16:0]        fetch_ptr;
  logic               frame_closed;

  color_word_t color_q [$];
  color_word_t expected_word;

  // floor((v - min) * 512 / (max - min)), clamped to 511; 0 on a flat frame
  function automatic logic [8:0] color_index(logic signed [15:0] v);
    longint span;
    longint offset;
    longint quot;
    span = longint'(max_sample) - longint'(min_sample);
    if (span == 0 || v <= min_sample) begin
      return 9'd0;
    end
    offset = longint'(v) - longint'(min_sample);
    quot   = (offset * 512) / span;
    return (quot > 511) ? 9'd511 : quot[8:0];
  endfunction

  // Lower half: blue to green; upper half: green to red
  function automatic color_word_t pixel_color(logic [8:0] idx, logic last);
    color_word_t w;
    if (idx < 9'd256) begin
      w.red   = 8'd0;
      w.green = idx[7:0];
      w.blue  = 8'(9'd255 - idx);
    end else begin
      w.red   = 8'(idx - 9'd256);
      w.green = 8'(9'd511 - idx);
      w.blue  = 8'd0;
    end
    w.last = last;
    return w;
  endfunction

  // Advance the shadow state by one accepted word
  task automatic predict_word(input logic cmd, input logic signed [15:0] smp,
                              input logic fe);
    logic last;
    if (cmd == mmfc_pkg::CMD_LOAD) begin
      // a load after a closed frame opens a new one
      if (frame_closed) begin
        frame_closed = 1'b0;
        pixel_count  = '0;
        fetch_ptr    = '0;
      end
      // pixels past capacity are dropped, but their frame_end still counts
      if (pixel_count < MAX_PIXELS) begin
        frame_mem[pixel_count] = smp;
        if (pixel_count == 0) begin
          min_sample = smp;
          max_sample = smp;
        end else begin
          if (smp < min_sample) min_sample = smp;
          if (smp > max_sample) max_sample = smp;
        end
        pixel_count = pixel_count + 1'b1;
      end
      if (fe) begin
        frame_closed = 1'b1;
        fetch_ptr    = '0;
      end
    end else begin
      if (!frame_closed || pixel_count == 0) begin
        return;
      end
      if (fetch_ptr >= pixel_count) fetch_ptr = '0;
      last = (fetch_ptr + 1'b1 == pixel_count);
      color_q.push_back(pixel_color(color_index(frame_mem[fetch_ptr]), last));
      fetch_ptr = last ? '0 : fetch_ptr + 1'b1;
    end
  endtask

  // Compare the color word first, then take the new command word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sample       = '0;
      max_sample       = '0;
      pixel_count      = '0;
      fetch_ptr        = '0;
      frame_closed     = 1'b0;
      mismatch_count_o = 0;
      checked_o        = 0;
      color_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (color_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: color word with none expected: actual r=%0d g=%0d b=%0d last=%0b",
                   $time, red_i, green_i, blue_i, last_pixel_i);
        end else begin
          expected_word = color_q.pop_front();
          checked_o++;
          if (red_i !== expected_word.red || green_i !== expected_word.green ||
              blue_i !== expected_word.blue || last_pixel_i !== expected_word.last) begin
            mismatch_count_o++;
            $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d last=%0b, actual r=%0d g=%0d b=%0d last=%0b",
                     $time, expected_word.red, expected_word.green, expected_word.blue,
                     expected_word.last, red_i, green_i, blue_i, last_pixel_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_word(command_i, sample_i, frame_end_i);
      end
      pending_o <= color_q.size();
    end
  end

endmodule

// ===== test/tb_minmax_false_color_map.sv =====
// ----------------------------------------------------------------------------
// tb_minmax_false_color_map
// Drives load and fetch words into the false color map: a directed opening
// (extreme samples, both color halves, flat and single-pixel frames, fetches
// on open frames, replay after the last pixel), then random frames with
// random sender gaps, and a verdict.
// ----------------------------------------------------------------------------
module tb_minmax_false_color_map;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PIXELS = 65536;
  localparam int RUN_ITEMS   = 1400;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        command   = mmfc_pkg::CMD_LOAD;
  logic [15:0] sample    = '0;
  logic        frame_end = 1'b0;
  logic        busy;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;

  int mismatches;
  int pending;
  int checked;
  int cycle_count    = 0;
  int load_words     = 0;
  int fetch_words    = 0;
  int frame_count    = 0;
  int waited;
  int leftover;
  bit steady         = 1'b0;

  // 12 ns clock
  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  minmax_false_color_map dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .command_i   (command),
    .sample_i    (sample),
    .frame_end_i (frame_end),
    .done_o      (done),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .last_pixel_o(last_pixel)
  );

  minmax_false_color_map_checker #(
    .MAX_PIXELS(MAX_PIXELS)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .command_i       (command),
    .sample_i        (sample),
    .frame_end_i     (frame_end),
    .done_i          (done),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .last_pixel_i    (last_pixel),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One word: optional idle gap, then hold start until busy is low at an edge
  task automatic send_word(input logic cmd, input logic [15:0] smp, input logic fe);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    sample    <= smp;
    frame_end <= fe;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == mmfc_pkg::CMD_LOAD) load_words++;
    else fetch_words++;
  endtask

  task automatic send_fetch();
    send_word(mmfc_pkg::CMD_FETCH, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Sample shapes: full range, narrow band, extremes, flat
  function automatic logic [15:0] draw_sample(int mode, logic [15:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return base;
    endcase
  endfunction

  // A frame of loads, sometimes left open or broken by stray fetches,
  // then, on a closed frame, a burst of fetches that may wrap around it
  task automatic run_frame();
    int          n;
    int          m;
    int          mode;
    logic [15:0] base;
    bit          close;
    n      = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    mode   = $urandom_range(0, 3);
    base   = 16'($urandom);
    close  = ($urandom_range(0, 9) != 0);
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) send_fetch();
      send_word(mmfc_pkg::CMD_LOAD, draw_sample(mode, base), close && (i == n - 1));
    end
    if (close) begin
      m = $urandom_range(0, 2 * n + 1);
      repeat (m) send_fetch();
    end
    frame_count++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fetch with no frame yet
    send_fetch();
    // Extremes: max clamps to 511, min gives 0, 0 and -1 straddle 256
    send_word(mmfc_pkg::CMD_LOAD, 16'h7FFF, 1'b0);
    send_word(mmfc_pkg::CMD_LOAD, 16'h8000, 1'b0);
    send_word(mmfc_pkg::CMD_LOAD, 16'h0000, 1'b0);
    send_word(mmfc_pkg::CMD_LOAD, 16'hFFFF, 1'b1);
    repeat (5) send_fetch();
    // Flat frame opened by a load after a closed frame; fetch while open
    send_word(mmfc_pkg::CMD_LOAD, 16'd1234, 1'b0);
    send_fetch();
    send_word(mmfc_pkg::CMD_LOAD, 16'd1234, 1'b0);
    send_word(mmfc_pkg::CMD_LOAD, 16'd1234, 1'b1);
    repeat (2) send_fetch();
    // Single-pixel frame: every fetch is the last pixel
    send_word(mmfc_pkg::CMD_LOAD, 16'd5, 1'b1);
    repeat (2) send_fetch();
    frame_count += 3;

    // Random frames
    while (load_words + fetch_words < RUN_ITEMS) begin
      run_frame();
    end
    start <= 1'b0;

    // Drain outstanding color words, then allow the fetch latency once more
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 500) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    leftover = pending;
    if (leftover != 0) begin
      $display("%0t: %0d expected color words never arrived", $time, leftover);
    end

    $display("Covered %0d load and %0d fetch words over %0d frames.",
             load_words, fetch_words, frame_count);
    $display("%0d color words compared, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && leftover == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
